// ----- hdl/aesg3_pkg.sv -----
// Shared types, constants and AES helper functions for the AES-G3 key derivation block.
// No dependencies.
package aesg3_pkg;

	localparam int NumExp = 10;             // key expansion stages
	localparam int NumStg = 20;             // total pipeline stages
	localparam logic [127:0] SEED = 128'h7B103C5DCB08C4E51A27B01799053BD9;

	localparam logic [1:0] KEY_LEFT  = 2'd0;
	localparam logic [1:0] KEY_PROC  = 2'd1;
	localparam logic [1:0] KEY_RIGHT = 2'd2;

	typedef struct packed {
		logic              vld;
		logic [1:0]        which;
		logic              last;
		logic [127:0]      st;
		logic [10:0][127:0] rk;
	} stage_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// seed with its last byte raised by the variant number
	function automatic logic [127:0] seed_of(input logic [1:0] which);
		seed_of = {SEED[127:8], SEED[7:0] + {6'd0, which}};
	endfunction

	// round key k from round key k-1; rc is that round's constant
	function automatic logic [127:0] next_rk(input logic [127:0] p, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {SBOX[p[23:16]] ^ rc, SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]};
		w0 = p[127:96] ^ t;
		w1 = p[95:64] ^ w0;
		w2 = p[63:32] ^ w1;
		w3 = p[31:0] ^ w2;
		next_rk = {w0, w1, w2, w3};
	endfunction

	// inverse ShiftRows and inverse SubBytes; byte i sits at [127-8i -: 8]
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] o;
		int r, c, src;
		o = '0;
		for (r = 0; r < 4; r++) begin
			for (c = 0; c < 4; c++) begin
				src = r + 4 * ((c - r) & 3);
				o[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
			end
		end
		inv_shift_sub = o;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] o;
		logic [3:0][7:0] a, m2, m4, m8, m9, m11, m13, m14;
		int c, j;
		o = '0;
		for (c = 0; c < 4; c++) begin
			for (j = 0; j < 4; j++) begin
				a[j] = s[127 - 8 * (4 * c + j) -: 8];
				m2[j] = xt(a[j]);
				m4[j] = xt(m2[j]);
				m8[j] = xt(m4[j]);
				m9[j] = m8[j] ^ a[j];
				m11[j] = m8[j] ^ m2[j] ^ a[j];
				m13[j] = m8[j] ^ m4[j] ^ a[j];
				m14[j] = m8[j] ^ m4[j] ^ m2[j];
			end
			o[127 - 8 * (4 * c) -: 8]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
			o[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
			o[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
			o[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		end
		inv_mix = o;
	endfunction

endpackage

// ----- hdl/aesg3_pipe.sv -----
// Twenty-stage AES-128 key expansion and inverse cipher pipeline.
// Depends on aesg3_pkg. Stages 1-10 expand the key, 11-19 run rounds 9..1, 20 finishes.
module aesg3_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  aesg3_pkg::stage_t head,
	output aesg3_pkg::stage_t tail
);

	aesg3_pkg::stage_t pipe_s [aesg3_pkg::NumStg + 1];
	aesg3_pkg::stage_t nxt [1:aesg3_pkg::NumStg];

	assign pipe_s[0] = head;

	genvar k;
	generate
		for (k = 1; k <= aesg3_pkg::NumStg; k++) begin : g_stg
			if (k <= aesg3_pkg::NumExp) begin : g_exp
				always_comb begin
					nxt[k] = pipe_s[k-1];
					nxt[k].rk[k] = aesg3_pkg::next_rk(pipe_s[k-1].rk[k-1],
						aesg3_pkg::RCON[k-1]);
					// initial AddRoundKey as soon as the last round key exists
					if (k == aesg3_pkg::NumExp)
						nxt[k].st = pipe_s[k-1].st ^ nxt[k].rk[aesg3_pkg::NumExp];
				end
			end else if (k < aesg3_pkg::NumStg) begin : g_rnd
				always_comb begin
					nxt[k] = pipe_s[k-1];
					nxt[k].st = aesg3_pkg::inv_mix(aesg3_pkg::inv_shift_sub(pipe_s[k-1].st)
						^ pipe_s[k-1].rk[aesg3_pkg::NumStg - k]);
				end
			end else begin : g_fin
				always_comb begin
					nxt[k] = pipe_s[k-1];
					nxt[k].st = aesg3_pkg::inv_shift_sub(pipe_s[k-1].st) ^ pipe_s[k-1].rk[0]
						^ aesg3_pkg::seed_of(pipe_s[k-1].which);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pipe_s[k] <= '0;
				end else if (adv) begin
					pipe_s[k] <= nxt[k];
				end
			end
		end
	endgenerate

	assign tail = pipe_s[aesg3_pkg::NumStg];

endmodule

// ----- hdl/aes_g3_key_derivation.sv -----
// Top level of the AES-G3 key derivation: splits requests into decryptions, drives output.
// Depends on aesg3_pkg and aesg3_pipe.
//
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// key in   | key_valid/key_ready  | key_hi, key_lo, want_left/processing/right
// derived  | drv_valid/drv_ready  | which_key, derived_hi, derived_lo, last
//
// One decryption enters the 20-stage pipeline per cycle while it advances; an input with
// n flags issues n decryptions, and one with no flag set is accepted without any.
// The whole pipeline advances when the output stage is empty or taken; a stall freezes it.
// Reset clears all stage valid bits and the issue mask.
module aes_g3_key_derivation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_ready,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	input  logic        want_left,
	input  logic        want_processing,
	input  logic        want_right,
	output logic        drv_valid,
	input  logic        drv_ready,
	output logic [1:0]  which_key,
	output logic [63:0] derived_hi,
	output logic [63:0] derived_lo,
	output logic        last
);

	logic [2:0] done_q;
	logic [2:0] want;
	logic [2:0] pend;
	logic [2:0] rest;
	logic [1:0] sel;
	logic       adv;
	logic       issue;
	aesg3_pkg::stage_t head;
	aesg3_pkg::stage_t tail;

	assign want = {want_right, want_processing, want_left};
	assign pend = want & ~done_q;
	assign adv  = !tail.vld || drv_ready;

	always_comb begin
		if (pend[0])
			sel = aesg3_pkg::KEY_LEFT;
		else if (pend[1])
			sel = aesg3_pkg::KEY_PROC;
		else
			sel = aesg3_pkg::KEY_RIGHT;
	end

	// requests left after the one issued now
	always_comb begin
		case (sel)
			aesg3_pkg::KEY_LEFT: rest = {pend[2:1], 1'b0};
			aesg3_pkg::KEY_PROC: rest = {pend[2], 2'b00};
			default:             rest = 3'b000;
		endcase
	end

	assign issue     = key_valid && (pend != 3'b000) && adv;
	assign key_ready = key_valid && ((pend == 3'b000) || (adv && (rest == 3'b000)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (key_valid && key_ready) begin
			done_q <= '0;
		end else if (issue) begin
			done_q <= done_q | (3'b001 << sel);
		end
	end

	always_comb begin
		head       = '0;
		head.vld   = issue;
		head.which = sel;
		head.last  = (rest == 3'b000);
		head.st    = aesg3_pkg::seed_of(sel);
		head.rk[0] = {key_hi, key_lo};
	end

	aesg3_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.head   (head),
		.tail   (tail)
	);

	assign drv_valid  = tail.vld;
	assign which_key  = tail.which;
	assign derived_hi = tail.st[127:64];
	assign derived_lo = tail.st[63:0];
	assign last       = tail.last;

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid |-> ((done_q & ~want) == 3'b000))
		else $error("issued mask holds an unrequested variant");

	a_issue_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && key_ready && (want != 3'b000)) |-> issue)
		else $error("input accepted without issuing its final decryption");

	a_which_range: assert property (@(posedge clk) disable iff (!arst_n)
		drv_valid |-> (which_key != 2'd3))
		else $error("invalid variant code at output");

	a_no_issue_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && !drv_ready) |-> !issue)
		else $error("decryption issued while pipeline stalled");

endmodule

// ----- sim/testbench.sv -----
// Testbench for aes_g3_key_derivation: drives keys with request flags, predicts each
// derived key with a behavioral AES-128 inverse cipher and checks every output transaction.
// Depends on aesg3_pkg (key variant codes) and the RTL top level.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam logic [127:0] SEED_BLOCK = 128'h7B103C5DCB08C4E51A27B01799053BD9;

	typedef struct {
		logic [1:0]  which;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} derived_t;

	logic        clk;
	logic        arst_n;
	logic        key_valid;
	logic        key_ready;
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic        want_left;
	logic        want_processing;
	logic        want_right;
	logic        drv_valid;
	logic        drv_ready;
	logic [1:0]  which_key;
	logic [63:0] derived_hi;
	logic [63:0] derived_lo;
	logic        last;

	derived_t    pending_keys[$];
	logic [7:0]  fwd_sbox[256];
	logic [7:0]  rev_sbox[256];
	int          errors = 0;
	int          idle_cycles;
	int          burst_left;
	bit          stall_on;

	aes_g3_key_derivation dut (
		.clk(clk), .arst_n(arst_n),
		.key_valid(key_valid), .key_ready(key_ready),
		.key_hi(key_hi), .key_lo(key_lo),
		.want_left(want_left), .want_processing(want_processing), .want_right(want_right),
		.drv_valid(drv_valid), .drv_ready(drv_ready),
		.which_key(which_key), .derived_hi(derived_hi), .derived_lo(derived_lo),
		.last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// S-box built from the field inverse and affine map
	task automatic build_sboxes();
		logic [7:0] inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			for (int k = 0; k < 254; k++)
				inv = gmul(inv, x[7:0]);
			if (x == 0)
				inv = 8'h00;
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sbox[x] = s;
			rev_sbox[s] = x[7:0];
		end
	endtask

	// byte i of a block sits at [127-8i -: 8]
	function automatic logic [127:0] aes_inv_cipher(input logic [127:0] key,
			input logic [127:0] blk);
		logic [127:0] rkeys[11];
		logic [127:0] st, o;
		logic [31:0]  t, w[4];
		logic [7:0]   rc, a0, a1, a2, a3;
		rc = 8'h01;
		rkeys[0] = key;
		for (int r = 1; r <= 10; r++) begin
			for (int j = 0; j < 4; j++)
				w[j] = rkeys[r - 1][127 - 32 * j -: 32];
			t = {fwd_sbox[w[3][23:16]] ^ rc, fwd_sbox[w[3][15:8]], fwd_sbox[w[3][7:0]],
				fwd_sbox[w[3][31:24]]};
			w[0] ^= t;
			w[1] ^= w[0];
			w[2] ^= w[1];
			w[3] ^= w[2];
			rkeys[r] = {w[0], w[1], w[2], w[3]};
			rc = gmul(rc, 8'h02);
		end
		st = blk ^ rkeys[10];
		for (int r = 9; r >= 0; r--) begin
			for (int row = 0; row < 4; row++)
				for (int c = 0; c < 4; c++)
					o[127 - 8 * (row + 4 * c) -: 8] =
						rev_sbox[st[127 - 8 * (row + 4 * ((c - row) & 3)) -: 8]];
			st = o ^ rkeys[r];
			if (r > 0) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[127 - 32 * c -: 8];
					a1 = st[119 - 32 * c -: 8];
					a2 = st[111 - 32 * c -: 8];
					a3 = st[103 - 32 * c -: 8];
					o[127 - 32 * c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11)
						^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
					o[119 - 32 * c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14)
						^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
					o[111 - 32 * c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9)
						^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
					o[103 - 32 * c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13)
						^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
				end
				st = o;
			end
		end
		return st;
	endfunction

	task automatic predict_derivation(input logic [63:0] khi, input logic [63:0] klo,
			input logic [2:0] wants);
		logic [127:0] sd, dk;
		derived_t     d;
		int           total, n;
		logic [1:0]   variant[3];
		total = int'(wants[0]) + int'(wants[1]) + int'(wants[2]);
		n = 0;
		variant[0] = aesg3_pkg::KEY_LEFT;
		variant[1] = aesg3_pkg::KEY_PROC;
		variant[2] = aesg3_pkg::KEY_RIGHT;
		for (int v = 0; v < 3; v++) begin
			if (wants[v]) begin
				sd = {SEED_BLOCK[127:8], SEED_BLOCK[7:0] + 8'(v)};
				dk = aes_inv_cipher({khi, klo}, sd) ^ sd;
				n++;
				d.which = variant[v];
				d.hi = dk[127:64];
				d.lo = dk[63:0];
				d.last = (n == total);
				pending_keys.push_back(d);
			end
		end
	endtask

	// valid drops only ahead of a real gap, so key_valid sees one assignment per step
	task automatic send_key(input logic [63:0] khi, input logic [63:0] klo,
			input logic [2:0] wants);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				key_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		key_valid <= 1'b1;
		key_hi <= khi;
		key_lo <= klo;
		want_left <= wants[0];
		want_processing <= wants[1];
		want_right <= wants[2];
		predict_derivation(khi, klo, wants);
		do
			@(posedge clk);
		while (!key_ready);
	endtask

	task automatic wait_drained();
		key_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_keys.size() != 0);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		send_key('0, '0, 3'b111);
		send_key('1, '1, 3'b111);
		send_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 3'b000);
		for (int w = 0; w < 8; w++)
			send_key(rand64(), rand64(), w[2:0]);
		send_key('1, '0, 3'b001);
		send_key('0, '1, 3'b100);
		send_key(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 3'b010);
		send_key(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 3'b101);
		send_key(64'h8000000000000000, 64'h0000000000000001, 3'b011);
		send_key(64'h0000000000000001, 64'h8000000000000000, 3'b110);
	endtask

	task automatic test_no_request_run();
		for (int i = 0; i < 6; i++)
			send_key(rand64(), rand64(), 3'b000);
		send_key(rand64(), rand64(), 3'b100);
	endtask

	task automatic test_random(input int count);
		logic [2:0] wants;
		for (int i = 0; i < count; i++) begin
			wants = $urandom_range(0, 9) == 0 ? 3'b000 : 3'($urandom_range(1, 7));
			send_key(rand64(), rand64(), wants);
		end
	endtask

	task automatic test_pause_until_drained();
		send_key(rand64(), rand64(), 3'b111);
		wait_drained();
		send_key(rand64(), rand64(), 3'b111);
		send_key(rand64(), rand64(), 3'b010);
	endtask

	// receiver stall pattern: alternates stalling and free-running stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_on <= 1'b0;
			drv_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 15) == 0)
				stall_on <= !stall_on;
			drv_ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		derived_t exp_key;
		if (arst_n && drv_valid && drv_ready) begin
			if (pending_keys.size() == 0) begin
				$error("unexpected derived key which_key=%0d", which_key);
				errors++;
			end else begin
				exp_key = pending_keys.pop_front();
				if (which_key !== exp_key.which) begin
					$error("which_key exp %0d got %0d", exp_key.which, which_key);
					errors++;
				end
				if (derived_hi !== exp_key.hi) begin
					$error("derived_hi exp %h got %h", exp_key.hi, derived_hi);
					errors++;
				end
				if (derived_lo !== exp_key.lo) begin
					$error("derived_lo exp %h got %h", exp_key.lo, derived_lo);
					errors++;
				end
				if (last !== exp_key.last) begin
					$error("last exp %0d got %0d", exp_key.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (key_valid && key_ready) || (drv_valid && drv_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		burst_left = 0;
		arst_n = 1'b0;
		key_valid = 1'b0;
		key_hi = '0;
		key_lo = '0;
		want_left = 1'b0;
		want_processing = 1'b0;
		want_right = 1'b0;
		build_sboxes();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_request_run();
		test_pause_until_drained();
		test_random(220);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_keys.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
